// ----- sv/first_fit_free_list_allocator_unit_macros.svh -----
// Assertion macros for the free-list allocator.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
package ffa_pkg;

  localparam int unsigned DefMaxRegions = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 11;
  localparam logic [DataW-1:0] RoundAdd = 32'h0000_0fff;
  localparam logic [DataW-1:0] RoundMask = 32'hffff_f000;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request
    logic rd_en;       // read entry at rd_idx
    logic scan_step;   // evaluate read data against the request
    logic wr_cur;      // write working entry at ptr
    logic wr_ins;      // write new entry at ptr
    logic move_dn;     // copy entry ptr+1 to ptr (removal)
    logic move_up;     // copy entry ptr-1 to ptr (insertion)
    logic ptr_inc;
    logic ptr_dec;
    logic ptr_to_cnt;  // ptr = count
    logic mark;        // remember ptr as the insertion slot
    logic cnt_inc;
    logic cnt_dec;
    logic finish;      // produce the result
  } ffa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic at_end;      // ptr has reached the entry count
    logic at_mark;     // ptr has reached the insertion slot
    logic hit;         // scan condition met on the current read
    logic merge_lo;
    logic merge_hi;
    logic len_zero;    // allocated entry became empty
    logic full;
  } ffa_sts_t;

endpackage

// ----- sv/ffa_datapath.sv -----
module ffa_datapath #(
  parameter int unsigned MaxRegions = ffa_pkg::DefMaxRegions
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ffa_pkg::ffa_cmd_t         cmd_i,
  output ffa_pkg::ffa_sts_t         sts_o,
  input  logic                      op_i,
  input  logic [31:0]               region_addr_i,
  input  logic [31:0]               region_size_i,
  input  logic                      round_4k_i,
  input  logic                      ok_i,
  output logic [31:0]               alloc_addr_o,
  output logic                      failed_o,
  output logic [31:0]               free_total_o,
  output logic [10:0]               entry_count_o,
  output logic [10:0]               peak_entries_o,
  output logic [31:0]               lost_count_o,
  output logic [31:0]               lost_bytes_o
);
  import ffa_pkg::*;

  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  // Region table: start and length in one word.
  logic [2*DataW-1:0] mem_q [MaxRegions];
  logic [2*DataW-1:0] rd_q;

  logic              op_q;
  logic [DataW-1:0]  addr_q, size_q, top_q;
  logic [CntW-1:0]   cnt_q, peak_q, ptr_q, ins_q;
  logic [DataW-1:0]  total_q, lost_cnt_q, lost_bytes_q;
  logic [DataW-1:0]  res_addr_q;
  logic              mlo_q;
  logic [DataW-1:0]  prev_start_q, prev_len_q;
  logic [DataW-1:0]  wk_start_q, wk_len_q;

  logic [DataW-1:0]  rd_start, rd_len, size_in;
  logic [CntW-1:0]   rd_idx_full;
  logic [IdxW-1:0]   rd_idx, wr_idx;
  logic [2*DataW-1:0] wr_data;
  logic              wr_en;

  assign rd_start = rd_q[2*DataW-1:DataW];
  assign rd_len   = rd_q[DataW-1:0];
  assign size_in  = round_4k_i ? ((region_size_i + RoundAdd) & RoundMask) : region_size_i;

  // Read address: neighbor for moves, else the pointer.
  always_comb begin
    rd_idx_full = ptr_q;
    if (cmd_i.move_dn) rd_idx_full = ptr_q + CntW'(1);
    if (cmd_i.move_up) rd_idx_full = ptr_q - CntW'(1);
  end
  assign rd_idx = rd_idx_full[IdxW-1:0];
  assign wr_idx = ptr_q[IdxW-1:0];

  // Write data select.
  always_comb begin
    wr_en   = cmd_i.wr_cur | cmd_i.wr_ins;
    wr_data = {wk_start_q, wk_len_q};
    if (cmd_i.wr_ins) wr_data = {addr_q, size_q};
  end

  // Table memory: one write and one registered read per cycle. A move reads
  // the neighbor in one cycle and writes it in the next (see controller).
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_data;
    else if ((cmd_i.move_dn || cmd_i.move_up) && !cmd_i.rd_en) mem_q[wr_idx] <= rd_q;
    if (cmd_i.rd_en) rd_q <= mem_q[rd_idx];
  end

  // Status toward the controller.
  always_comb begin
    sts_o.is_free  = (op_q == OpFree);
    sts_o.at_end   = (ptr_q == cnt_q);
    sts_o.at_mark  = (ptr_q == ins_q);
    sts_o.full     = (cnt_q == CntW'(MaxRegions));
    sts_o.hit      = (op_q == OpFree) ? (rd_start > addr_q) : (rd_len >= size_q);
    sts_o.merge_lo = mlo_q;
    sts_o.merge_hi = (top_q == rd_start);
    sts_o.len_zero = (wk_len_q == '0);
  end

  // Request registers, counters and working entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; peak_q <= '0; ptr_q <= '0; ins_q <= '0;
      total_q <= '0; lost_cnt_q <= '0; lost_bytes_q <= '0;
      op_q <= OpAlloc; mlo_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q <= op_i; addr_q <= region_addr_i; size_q <= size_in;
        top_q <= region_addr_i + size_in; ptr_q <= '0; mlo_q <= 1'b0;
        res_addr_q <= '0;
      end
      if (cmd_i.mark) ins_q <= ptr_q;
      if (cmd_i.ptr_inc) ptr_q <= ptr_q + CntW'(1);
      if (cmd_i.ptr_dec) ptr_q <= ptr_q - CntW'(1);
      if (cmd_i.ptr_to_cnt) ptr_q <= cnt_q;
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
        if (peak_q < cnt_q + CntW'(1)) peak_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.cnt_dec) cnt_q <= cnt_q - CntW'(1);
      // Scan step on the freshly read entry.
      if (cmd_i.scan_step) begin
        if (op_q == OpAlloc) begin
          if (rd_len >= size_q) begin
            res_addr_q <= rd_start;
            wk_start_q <= rd_start + size_q;
            wk_len_q   <= rd_len - size_q;
            total_q    <= total_q - size_q;
          end
        end else if (rd_start > addr_q) begin
          // Upper neighbor candidate: merge into lower or into this one.
          if (mlo_q) begin
            wk_start_q <= prev_start_q;
            wk_len_q   <= prev_len_q + size_q + ((top_q == rd_start) ? rd_len : '0);
          end else begin
            wk_start_q <= addr_q;
            wk_len_q   <= rd_len + size_q;
          end
        end else begin
          prev_start_q <= rd_start; prev_len_q <= rd_len;
          mlo_q <= (rd_start + rd_len == addr_q);
          wk_start_q <= rd_start;
          wk_len_q   <= rd_len + size_q;
        end
      end
      if (cmd_i.finish) begin
        if (op_q == OpFree) begin
          if (ok_i) total_q <= total_q + size_q;
          else begin
            lost_cnt_q   <= lost_cnt_q + 32'd1;
            lost_bytes_q <= lost_bytes_q + size_q;
          end
        end
        if (!ok_i) res_addr_q <= '0;
      end
    end
  end

  assign alloc_addr_o   = (op_q == OpFree) ? '0 : res_addr_q;
  assign failed_o       = ~ok_i;
  assign free_total_o   = total_q;
  assign entry_count_o  = 11'(cnt_q);
  assign peak_entries_o = 11'(peak_q);
  assign lost_count_o   = lost_cnt_q;
  assign lost_bytes_o   = lost_bytes_q;

endmodule

// ----- sv/ffa_ctrl.sv -----
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ffa_pkg::ffa_sts_t sts_i,
  output ffa_pkg::ffa_cmd_t cmd_o,
  output logic              busy_o,
  output logic              ok_o,
  output logic              done_o
);
  import ffa_pkg::*;

  typedef enum logic [10:0] {
    StIdle   = 11'b000_0000_0001,
    StRead   = 11'b000_0000_0010,
    StEval   = 11'b000_0000_0100,
    StDecide = 11'b000_0000_1000,
    StRemRd  = 11'b000_0001_0000,
    StRemMv  = 11'b000_0010_0000,
    StInsRd  = 11'b000_0100_0000,
    StInsMv  = 11'b000_1000_0000,
    StWrite  = 11'b001_0000_0000,
    StLoad   = 11'b010_0000_0000,
    StDone   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic ok_q, ok_d, hi_q, hi_d, found_q, found_d;

  // Alloc: scan until hit, then write back or remove; fail if nothing fits.
  // Free: scan to first start above addr; the lower neighbor is the entry
  // before it. Then merge into one entry (possibly removing the upper one)
  // or shift the tail up and insert, failing when the table is full.
  always_comb begin
    state_d = state_q; ok_d = ok_q; hi_d = hi_q; found_d = found_q;
    cmd_o = '0; done_o = 1'b0;
    case (state_q)
      StIdle: if (start_i) begin
        cmd_o.load = 1'b1; ok_d = 1'b1; hi_d = 1'b0; found_d = 1'b0;
        state_d = StLoad;
      end
      StLoad: state_d = StRead;
      StRead: begin
        if (sts_i.at_end) state_d = StDecide;
        else begin
          cmd_o.rd_en = 1'b1; state_d = StEval;
        end
      end
      StEval: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          found_d = 1'b1;
          hi_d = sts_i.is_free & sts_i.merge_hi;
          state_d = StDecide;
        end else begin
          cmd_o.ptr_inc = 1'b1; state_d = StRead;
        end
      end
      StDecide: begin
        if (!sts_i.is_free) begin
          if (!found_q) begin
            ok_d = 1'b0; state_d = StDone;
          end else if (sts_i.len_zero) begin
            cmd_o.cnt_dec = 1'b1; state_d = StRemRd;
          end else begin
            cmd_o.wr_cur = 1'b1; state_d = StDone;
          end
        end else if (sts_i.merge_lo) begin
          // Lower entry is at ptr-1; write merged entry there.
          cmd_o.ptr_dec = 1'b1; state_d = StWrite;
        end else if (found_q && hi_q) begin
          cmd_o.wr_cur = 1'b1; state_d = StDone;
        end else if (sts_i.full) begin
          ok_d = 1'b0; state_d = StDone;
        end else begin
          // Remember the insertion slot and start the shift at the old top.
          cmd_o.mark = 1'b1; cmd_o.ptr_to_cnt = 1'b1;
          cmd_o.cnt_inc = 1'b1; state_d = StInsRd;
        end
      end
      StWrite: begin
        cmd_o.wr_cur = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (found_q && hi_q) begin
          cmd_o.cnt_dec = 1'b1; state_d = StRemRd;
        end else state_d = StDone;
      end
      // Removal: ptr is the removed slot; shift later entries down.
      StRemRd: begin
        if (sts_i.at_end) state_d = StDone;
        else begin
          cmd_o.rd_en = 1'b1; cmd_o.move_dn = 1'b1; state_d = StRemMv;
        end
      end
      StRemMv: begin
        cmd_o.move_dn = 1'b1; cmd_o.ptr_inc = 1'b1; state_d = StRemRd;
      end
      // Insertion: walk down from the old top, moving each entry up by one,
      // then write the new entry into the freed slot.
      StInsRd: begin
        if (sts_i.at_mark) begin
          cmd_o.wr_ins = 1'b1; state_d = StDone;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.move_up = 1'b1; state_d = StInsMv;
        end
      end
      StInsMv: begin
        cmd_o.move_up = 1'b1; cmd_o.ptr_dec = 1'b1; state_d = StInsRd;
      end
      StDone: begin
        done_o = 1'b1; cmd_o.finish = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ok_q <= 1'b0; hi_q <= 1'b0; found_q <= 1'b0;
    end else begin
      state_q <= state_d; ok_q <= ok_d; hi_q <= hi_d; found_q <= found_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign ok_o   = ok_q;

endmodule

// ----- sv/first_fit_free_list_allocator_unit.sv -----
// An item's run time is set by the table scan and the entry shift, each of which
// reads a table entry and then evaluates or moves it in a separate state.
// Throughput: one item at a time; busy drops as the result strobe rises, so the
// next item is accepted at the earliest on the edge that takes the result.
// Reset (rst_ni low, asynchronous) empties the list and clears all counters.
module first_fit_free_list_allocator_unit #(
  parameter int unsigned MaxRegions = ffa_pkg::DefMaxRegions
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [31:0] region_addr_i,
  input  logic [31:0] region_size_i,
  input  logic        round_4k_i,
  output logic        valid_o,
  output logic [31:0] alloc_addr_o,
  output logic        failed_o,
  output logic [31:0] free_total_o,
  output logic [10:0] entry_count_o,
  output logic [10:0] peak_entries_o,
  output logic [31:0] lost_count_o,
  output logic [31:0] lost_bytes_o
);
  import ffa_pkg::*;
  `include "first_fit_free_list_allocator_unit_macros.svh"

  ffa_cmd_t cmd;
  ffa_sts_t sts;
  logic ok, done, valid_q;

  ffa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .ok_o(ok), .done_o(done)
  );

  ffa_datapath #(.MaxRegions(MaxRegions)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i, .region_addr_i, .region_size_i, .round_4k_i, .ok_i(ok),
    .alloc_addr_o, .failed_o, .free_total_o, .entry_count_o,
    .peak_entries_o, .lost_count_o, .lost_bytes_o
  );

  // Result strobe follows the finish cycle, when the counters are updated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= done;
  end
  assign valid_o = valid_q;

  `FFA_ASSERT_NEXT(a_strobe_one, clk_i, rst_ni, valid_o, !valid_o, "result strobe held")
  `FFA_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, 32'(entry_count_o) <= MaxRegions, "count overflow")
  `FFA_ASSERT_IMPL(a_free_addr, clk_i, rst_ni, valid_o && failed_o, alloc_addr_o == '0, "failed with address")

endmodule
